[rtl/core/ntf_pkg.sv]
// ----------------------------------------------------------------------------
// ntf_pkg
// Shared constants for the neighborhood thicken filter: size defaults,
// register indexes and pixel codes.
// ----------------------------------------------------------------------------
package ntf_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 128;

    // configuration register file
    localparam int FW_BITS  = 9;
    localparam int FH_BITS  = 8;
    localparam int CFG_BITS = 9;
    localparam int IDX_BITS = 1;

    localparam logic [IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_BITS-1:0] FRAME_WIDTH_RESET  = 9'd160;
    localparam logic [FH_BITS-1:0] FRAME_HEIGHT_RESET = 8'd120;

    // pixel codes in the biased (offset by 128) domain and on the output
    localparam logic [7:0] PIX_BIAS     = 8'h80;
    localparam logic [7:0] BIASED_TOP   = 8'hFF;
    localparam logic [7:0] PIX_MAX_CODE = 8'h7F;
    localparam logic [7:0] PIX_MIN_CODE = 8'h80;

    // neighborhood sum: at most ten terms of 255
    localparam int SUM_BITS = 12;
    localparam int NBR_DIVISOR = 9;

    // divide by nine as a multiply by ceil(2^16 / 9) and a shift;
    // exact for every sum below 32768
    localparam int RECIP_BITS = 13;
    localparam logic [RECIP_BITS-1:0] NBR_RECIP = 13'd7282;
    localparam int NBR_SHIFT = 16;

endpackage

[rtl/core/ntf_div.sv]
// ----------------------------------------------------------------------------
// ntf_div
// Restoring radix-2 divider, one quotient bit per cycle, used to split the
// readout position into row and column.
// ----------------------------------------------------------------------------
module ntf_div #(
    parameter int DVD_W = 16,
    parameter int DVS_W = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   trial;
    logic             fits;
    logic [DVS_W:0]   diff;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, keep the difference when it fits
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[rtl/core/neighborhood_thicken_filter.sv]
// ----------------------------------------------------------------------------
// neighborhood_thicken_filter
// Frame store with a 3x3 thickening filter read out one pixel per fetch.
// ----------------------------------------------------------------------------
// Usage: raise start with op and pixel_in while busy is low; the item is
// taken at that edge and busy rises until the item is finished. op 0 loads
// the next pixel of the frame in raster order. op 1 fetches the next
// filtered pixel; done pulses for one cycle with pixel_out and last.
// A fetch runs one divide on the restoring divider (16 bits wide at the
// default frame size) to split the position into row and column, nine
// single-port memory reads to gather the neighborhood, and a multiply by
// the reciprocal of nine to form the average. Fetches before the frame
// is complete and loads during readout finish without a result.
// Items cannot overlap: the next start is taken once busy drops.
// The receiver cannot stall; done is never held off.
// Frame size is written through wr_en/wr_index/wr_data; the user must write it while busy is low (not enforced here).
// Reset clears the load and readout positions and the frame flag; the
// frame memory itself is not cleared and needs no startup pass.
// ----------------------------------------------------------------------------
module neighborhood_thicken_filter #(
    parameter int MAX_WIDTH  = ntf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ntf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          op,
    input  logic signed [7:0]             pixel_in,
    output logic                          done,
    output logic signed [7:0]             pixel_out,
    output logic                          last,
    input  logic                          wr_en,
    input  logic [ntf_pkg::IDX_BITS-1:0]  wr_index,
    input  logic [ntf_pkg::CFG_BITS-1:0]  wr_data
);

    localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int POS_BITS  = $clog2(DEPTH + 1);
    localparam int WBITS     = $clog2(MAX_WIDTH + 1);
    localparam int HBITS     = $clog2(MAX_HEIGHT + 1);
    localparam int DVD_W     = POS_BITS;
    localparam int DVS_W     = WBITS;
    localparam int SA_BITS   = POS_BITS + 2;
    localparam int PROD_BITS = ntf_pkg::SUM_BITS + ntf_pkg::RECIP_BITS;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_LOAD   = 8'b0000_0010,
        S_FETCH  = 8'b0000_0100,
        S_DIVRC  = 8'b0000_1000,
        S_NBR    = 8'b0001_0000,
        S_DRAIN  = 8'b0010_0000,
        S_QSTART = 8'b0100_0000,
        S_QWAIT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [ntf_pkg::FW_BITS-1:0] fw_reg;
    logic [ntf_pkg::FH_BITS-1:0] fh_reg;
    logic [WBITS-1:0]            ew;
    logic [HBITS-1:0]            eh;

    // item and positions
    logic [7:0]              pix_reg;
    logic [POS_BITS-1:0]     size_reg;
    logic [POS_BITS-1:0]     lp_reg;
    logic [POS_BITS-1:0]     ep_reg;
    logic                    full_reg;

    // neighborhood walk
    logic [HBITS-1:0]        row_reg;
    logic [WBITS-1:0]        col_reg;
    logic signed [SA_BITS-1:0] addr_reg;
    logic [1:0]              dr_reg;
    logic [1:0]              dc_reg;
    logic                    pend_valid_reg;
    logic                    pend_center_reg;
    logic [ntf_pkg::SUM_BITS-1:0] acc_reg;
    logic [7:0]              center_reg;

    // average
    logic [PROD_BITS-1:0]    avg_prod;
    logic [ntf_pkg::SUM_BITS-1:0] avg_reg;

    // result
    logic                    done_reg;
    logic [7:0]              pix_out_reg;
    logic                    last_reg;

    // memory
    logic [7:0]              mem [DEPTH];
    logic [7:0]              mem_q;
    logic [ADDR_BITS-1:0]    mem_addr;
    logic                    mem_we;

    // divider
    logic                    div_start;
    logic [DVD_W-1:0]        div_dividend;
    logic [DVS_W-1:0]        div_divisor;
    logic                    div_done;
    logic [DVD_W-1:0]        div_quo;
    logic [DVS_W-1:0]        div_rem;

    logic                    accept;
    logic [POS_BITS-1:0]     size_m1;
    logic [POS_BITS-1:0]     ep_eff;
    logic [POS_BITS:0]       lp_inc;
    logic                    r_ok;
    logic                    c_ok;
    logic                    nbr_ok;
    logic [7:0]              mem_b;
    logic [ntf_pkg::SUM_BITS-1:0] acc_add;
    logic [7:0]              result;

    // ------------------------------------------------------------------
    // effective frame size: zero acts as one, clamp to the maxima
    // ------------------------------------------------------------------
    always_comb
    begin
        if (fw_reg == '0)
            ew = WBITS'(1);
        else if (int'(fw_reg) > MAX_WIDTH)
            ew = WBITS'(MAX_WIDTH);
        else
            ew = WBITS'(fw_reg);

        if (fh_reg == '0)
            eh = HBITS'(1);
        else if (int'(fh_reg) > MAX_HEIGHT)
            eh = HBITS'(MAX_HEIGHT);
        else
            eh = HBITS'(fh_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= ntf_pkg::FRAME_WIDTH_RESET;
            fh_reg <= ntf_pkg::FRAME_HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                ntf_pkg::REG_FRAME_WIDTH:  fw_reg <= wr_data[ntf_pkg::FW_BITS-1:0];
                ntf_pkg::REG_FRAME_HEIGHT: fh_reg <= wr_data[ntf_pkg::FH_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign accept  = start && (state_reg == S_IDLE);
    assign size_m1 = size_reg - 1'b1;
    assign ep_eff  = (ep_reg >= size_reg) ? size_m1 : ep_reg;
    assign lp_inc  = {1'b0, lp_reg} + 1'b1;

    // in-frame test for the current neighbor offset
    always_comb
    begin
        unique case (dr_reg)
            2'd0:    r_ok = (row_reg != '0);
            2'd2:    r_ok = ({1'b0, row_reg} + 1'b1) < {1'b0, eh};
            default: r_ok = 1'b1;
        endcase
        unique case (dc_reg)
            2'd0:    c_ok = (col_reg != '0);
            2'd2:    c_ok = ({1'b0, col_reg} + 1'b1) < {1'b0, ew};
            default: c_ok = 1'b1;
        endcase
    end
    assign nbr_ok = r_ok && c_ok;

    // ------------------------------------------------------------------
    // frame memory, single port
    // ------------------------------------------------------------------
    assign mem_we   = (state_reg == S_LOAD) && !full_reg && (lp_reg < size_reg);
    assign mem_addr = (state_reg == S_LOAD) ? lp_reg[ADDR_BITS-1:0]
                                            : addr_reg[ADDR_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= pix_reg;
        mem_q <= mem[mem_addr];
    end

    assign mem_b   = mem_q ^ ntf_pkg::PIX_BIAS;
    assign acc_add = !pend_valid_reg ? '0
                   : pend_center_reg ? ntf_pkg::SUM_BITS'({mem_b, 1'b0})
                   : ntf_pkg::SUM_BITS'(mem_b);

    // ------------------------------------------------------------------
    // row/column divider
    // ------------------------------------------------------------------
    assign div_start    = (state_reg == S_FETCH) && full_reg;
    assign div_dividend = DVD_W'(ep_eff);
    assign div_divisor  = DVS_W'(ew);

    ntf_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign avg_prod = PROD_BITS'(acc_reg) * PROD_BITS'(ntf_pkg::NBR_RECIP);

    always_comb
    begin
        if (center_reg == ntf_pkg::BIASED_TOP)
            result = ntf_pkg::PIX_MAX_CODE;
        else if (avg_reg == '0)
            result = ntf_pkg::PIX_MIN_CODE;
        else if (avg_reg > ntf_pkg::SUM_BITS'(127))
            result = ntf_pkg::PIX_MAX_CODE;
        else
            result = avg_reg[7:0];
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (start) state_next = op ? S_FETCH : S_LOAD;
            S_LOAD:   state_next = S_IDLE;
            S_FETCH:  state_next = full_reg ? S_DIVRC : S_IDLE;
            S_DIVRC:  if (div_done) state_next = S_NBR;
            S_NBR:    if ((dr_reg == 2'd2) && (dc_reg == 2'd2)) state_next = S_DRAIN;
            S_DRAIN:  state_next = S_QSTART;
            S_QSTART: state_next = S_QWAIT;
            S_QWAIT:  state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            lp_reg         <= '0;
            ep_reg         <= '0;
            full_reg       <= 1'b0;
            done_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;

            if ((state_reg == S_LOAD) && !full_reg)
            begin
                if ((lp_reg < size_reg) && (lp_inc < {1'b0, size_reg}))
                    lp_reg <= lp_inc[POS_BITS-1:0];
                else
                begin
                    // frame complete: arm readout
                    full_reg <= 1'b1;
                    lp_reg   <= '0;
                    ep_reg   <= '0;
                end
            end

            if ((state_reg == S_FETCH) && full_reg)
                ep_reg <= ep_eff;

            if (state_reg == S_DIVRC)
                pend_valid_reg <= 1'b0;
            else if (state_reg == S_NBR)
                pend_valid_reg <= nbr_ok;
            else
                pend_valid_reg <= 1'b0;

            if (state_reg == S_QWAIT)
            begin
                done_reg <= 1'b1;
                if (ep_reg == size_m1)
                begin
                    ep_reg   <= '0;
                    full_reg <= 1'b0;
                end
                else
                    ep_reg <= ep_reg + 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg  <= $unsigned(pixel_in);
            size_reg <= POS_BITS'(ew) * POS_BITS'(eh);
        end

        if ((state_reg == S_DIVRC) && div_done)
        begin
            row_reg  <= HBITS'(div_quo);
            col_reg  <= WBITS'(div_rem);
            // start at the upper-left neighbor
            addr_reg <= $signed({2'b00, ep_reg}) - $signed(SA_BITS'(ew)) - SA_BITS'(1);
            dr_reg   <= 2'd0;
            dc_reg   <= 2'd0;
            acc_reg  <= '0;
        end

        if (state_reg == S_NBR)
        begin
            pend_center_reg <= (dr_reg == 2'd1) && (dc_reg == 2'd1);
            if (dc_reg == 2'd2)
            begin
                // wrap to the next row of the block
                addr_reg <= addr_reg + $signed(SA_BITS'(ew)) - SA_BITS'(2);
                dc_reg   <= 2'd0;
                dr_reg   <= dr_reg + 1'b1;
            end
            else
            begin
                addr_reg <= addr_reg + SA_BITS'(1);
                dc_reg   <= dc_reg + 1'b1;
            end
        end

        if ((state_reg == S_NBR) || (state_reg == S_DRAIN))
        begin
            acc_reg <= acc_reg + acc_add;
            if (pend_valid_reg && pend_center_reg)
                center_reg <= mem_b;
        end

        if (state_reg == S_QSTART)
            avg_reg <= ntf_pkg::SUM_BITS'(avg_prod >> ntf_pkg::NBR_SHIFT);

        if (state_reg == S_QWAIT)
        begin
            pix_out_reg <= result;
            last_reg    <= (ep_reg == size_m1);
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign pixel_out = $signed(pix_out_reg);
    assign last      = last_reg;

endmodule

[sim/tb_neighborhood_thicken_filter.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_neighborhood_thicken_filter
// Self-checking bench for the 3x3 thickening filter. A short table of
// directed items covers the 1x1 and 3x3 corners, the kept 127 pixel, the
// -128 floor, early fetches and loads during readout. Random frames follow,
// with sizes from 1x1 up to the clamped register extremes, resized during
// load and readout, and checked against a behavioral model of the filter.
// ----------------------------------------------------------------------------
module tb_neighborhood_thicken_filter;

    localparam int CLK_PERIOD   = 10;
    localparam int MAX_W        = ntf_pkg::DEF_MAX_WIDTH;
    localparam int MAX_H        = ntf_pkg::DEF_MAX_HEIGHT;
    localparam int STORE_DEPTH  = MAX_W * MAX_H;
    localparam int RANDOM_ITEMS = 1060;
    localparam int CALM_ITEMS   = 120;
    // idle margin after every result is back
    localparam int DRAIN_CYCLES = 64;
    localparam longint TIMEOUT_NS = 64'd10_000_000;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_VALUE} chk_kind_t;
    typedef enum logic {ROW_SIZE, ROW_ITEM} row_kind_t;

    typedef struct {
        row_kind_t  kind;
        logic [8:0] w_val;
        logic [7:0] h_val;
        logic       op_v;
        logic [7:0] pix;
        chk_kind_t  chk;
        logic [7:0] t_pix;
        logic       t_last;
    } dir_row_t;

    typedef struct {
        logic [7:0] pix;
        logic       is_last;
    } pixel_expect_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       start    = 1'b0;
    logic       op       = 1'b0;
    logic [7:0] pixel_in = 8'h00;
    logic       wr_en    = 1'b0;
    logic [ntf_pkg::IDX_BITS-1:0] wr_index = '0;
    logic [ntf_pkg::CFG_BITS-1:0] wr_data  = '0;
    logic        busy;
    logic        done;
    logic signed [7:0] pixel_out;
    logic        last;

    // model of the block
    logic [7:0]    frame_mem [0:STORE_DEPTH-1];
    int            load_pos   = 0;
    int            emit_pos   = 0;
    bit            frame_full_q = 1'b0;
    logic [8:0]    width_reg  = ntf_pkg::FRAME_WIDTH_RESET;
    logic [7:0]    height_reg = ntf_pkg::FRAME_HEIGHT_RESET;

    pixel_expect_t pending_pixels[$];
    dir_row_t      dir_rows[$];
    int            err_count  = 0;
    int            item_count = 0;
    bit            gaps_on    = 1'b1;

    neighborhood_thicken_filter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .pixel_in  (pixel_in),
        .done      (done),
        .pixel_out (pixel_out),
        .last      (last),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int eff_dim(input int val, input int max_dim);
        if (val == 0)
            return 1;
        if (val > max_dim)
            return max_dim;
        return val;
    endfunction

    function automatic logic [7:0] thickened_pixel(input int pos, input int w, input int h);
        int row;
        int col;
        int r;
        int c;
        int acc;
        int q;
        logic [7:0] ctr;
        row = pos / w;
        col = pos % w;
        ctr = frame_mem[pos] ^ ntf_pkg::PIX_BIAS;
        // the center enters once on its own and once inside the 3x3 block
        acc = int'(ctr);
        for (r = row - 1; r <= row + 1; r++)
        begin
            for (c = col - 1; c <= col + 1; c++)
            begin
                if (r >= 0 && r < h && c >= 0 && c < w)
                    acc = acc + int'(frame_mem[r * w + c] ^ ntf_pkg::PIX_BIAS);
            end
        end
        if (ctr == ntf_pkg::BIASED_TOP)
            return ntf_pkg::PIX_MAX_CODE;
        q = acc / ntf_pkg::NBR_DIVISOR;
        if (q == 0)
            return ntf_pkg::PIX_MIN_CODE;
        if (q > int'(ntf_pkg::PIX_MAX_CODE))
            q = int'(ntf_pkg::PIX_MAX_CODE);
        return q[7:0];
    endfunction

    task automatic predict_item(input logic op_v, input logic [7:0] pix_v,
                                output bit has_out, output logic [7:0] out_pix,
                                output bit out_last);
        int w;
        int h;
        int size;
        w = eff_dim(int'(width_reg), MAX_W);
        h = eff_dim(int'(height_reg), MAX_H);
        size = w * h;
        has_out = 1'b0;
        out_pix = 8'h00;
        out_last = 1'b0;
        if (op_v == OP_LOAD)
        begin
            if (!frame_full_q)
            begin
                if (load_pos < size)
                begin
                    frame_mem[load_pos] = pix_v;
                    load_pos++;
                end
                else
                    load_pos = size;
                if (load_pos >= size)
                begin
                    frame_full_q = 1'b1;
                    load_pos = 0;
                    emit_pos = 0;
                end
            end
        end
        else if (frame_full_q)
        begin
            // a frame shrunk under readout saturates to its final pixel
            if (emit_pos >= size)
                emit_pos = size - 1;
            has_out = 1'b1;
            out_pix = thickened_pixel(emit_pos, w, h);
            if (emit_pos == size - 1)
            begin
                out_last = 1'b1;
                emit_pos = 0;
                frame_full_q = 1'b0;
            end
            else
                emit_pos++;
        end
    endtask

    // Drive one item and hold it until the block takes it. start stays high
    // on return so back-to-back items need no extra edge.
    task automatic send_item(input logic op_v, input logic [7:0] pix_v,
                             input chk_kind_t chk, input logic [7:0] t_pix,
                             input logic t_last);
        bit has_out;
        logic [7:0] exp_pix;
        bit exp_last;
        pixel_expect_t ent;
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start    <= 1'b1;
        op       <= op_v;
        pixel_in <= pix_v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_item(op_v, pix_v, has_out, exp_pix, exp_last);
        if (chk == CHK_VALUE)
        begin
            ent.pix = t_pix;
            ent.is_last = t_last;
            pending_pixels.push_back(ent);
        end
        else if (chk == CHK_MODEL && has_out)
        begin
            ent.pix = exp_pix;
            ent.is_last = exp_last;
            pending_pixels.push_back(ent);
        end
    endtask

    // Hold off until the block is idle and every result is back.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (busy || pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input logic [8:0] w_val, input logic [7:0] h_val);
        logic hi;
        wait_idle();
        hi = 1'($urandom_range(0, 1));
        wr_en    <= 1'b1;
        wr_index <= ntf_pkg::REG_FRAME_WIDTH;
        wr_data  <= w_val;
        @(posedge clk);
        // the spare top bit of the height write must be dropped
        wr_index <= ntf_pkg::REG_FRAME_HEIGHT;
        wr_data  <= {hi, h_val};
        @(posedge clk);
        wr_en <= 1'b0;
        width_reg  = w_val;
        height_reg = h_val;
    endtask

    function automatic void add_size(input logic [8:0] w_val, input logic [7:0] h_val);
        dir_row_t r;
        r.kind   = ROW_SIZE;
        r.w_val  = w_val;
        r.h_val  = h_val;
        r.op_v   = OP_LOAD;
        r.pix    = 8'h00;
        r.chk    = CHK_NONE;
        r.t_pix  = 8'h00;
        r.t_last = 1'b0;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_item(input logic op_v, input logic [7:0] pix,
                                     input chk_kind_t chk, input logic [7:0] t_pix,
                                     input logic t_last);
        dir_row_t r;
        r.kind   = ROW_ITEM;
        r.w_val  = '0;
        r.h_val  = '0;
        r.op_v   = op_v;
        r.pix    = pix;
        r.chk    = chk;
        r.t_pix  = t_pix;
        r.t_last = t_last;
        dir_rows.push_back(r);
    endfunction

    function automatic int pick_dim(input int max_dim, input int reg_top);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 6)
            return 0;
        if (sel < 10)
            return $urandom_range(max_dim + 1, reg_top);
        if (sel < 14)
            return max_dim;
        if (sel < 80)
            return $urandom_range(1, 6);
        return $urandom_range(7, 12);
    endfunction

    function automatic logic [7:0] pick_pixel(input bit dark);
        logic [7:0] v;
        v = 8'($urandom);
        if (dark)
        begin
            // near the bottom so the average can floor to zero
            v = 8'($urandom_range(0, 1));
            return ntf_pkg::PIX_MIN_CODE | v;
        end
        case ($urandom_range(0, 9))
            0: return ntf_pkg::PIX_MAX_CODE;
            1: return ntf_pkg::PIX_MIN_CODE;
            2: return ntf_pkg::PIX_MAX_CODE - 8'd1;
            default: return v;
        endcase
    endfunction

    task automatic run_frame(input int frame_no);
        logic [8:0] w_val;
        logic [7:0] h_val;
        bit dark;
        bit cut_load;
        bit cut_read;
        int cut_at;
        int done_n;
        int size_now;
        if (frame_no == 0)
        begin
            w_val = 9'h1FF;
            h_val = 8'hFF;
        end
        else if (frame_no == 1)
        begin
            w_val = 9'(MAX_W);
            h_val = 8'(MAX_H);
        end
        else
        begin
            w_val = 9'(pick_dim(MAX_W, 511));
            h_val = 8'(pick_dim(MAX_H, 255));
        end
        write_size(w_val, h_val);
        dark = ($urandom_range(0, 4) == 0);
        size_now = eff_dim(int'(w_val), MAX_W) * eff_dim(int'(h_val), MAX_H);
        // big frames are cut short by shrinking the size during the load
        cut_load = (size_now > 96) || ($urandom_range(0, 9) == 0);
        cut_at = $urandom_range(1, 24);
        done_n = 0;
        while (!frame_full_q)
        begin
            if (cut_load && done_n == cut_at)
            begin
                write_size(9'($urandom_range(1, 6)), 8'($urandom_range(1, 6)));
                cut_load = 1'b0;
            end
            if ($urandom_range(0, 24) == 0)
                send_item(OP_FETCH, 8'($urandom), CHK_MODEL, 8'h00, 1'b0);
            else
            begin
                send_item(OP_LOAD, pick_pixel(dark), CHK_MODEL, 8'h00, 1'b0);
                done_n++;
                item_count++;
            end
        end

        size_now = eff_dim(int'(width_reg), MAX_W) * eff_dim(int'(height_reg), MAX_H);
        cut_read = ($urandom_range(0, 7) == 0);
        cut_at = $urandom_range(0, size_now - 1);
        done_n = 0;
        while (frame_full_q)
        begin
            // only shrink here: a larger frame would read unwritten pixels
            if (cut_read && done_n == cut_at)
            begin
                write_size(9'($urandom_range(1, eff_dim(int'(width_reg), MAX_W))),
                           8'($urandom_range(1, eff_dim(int'(height_reg), MAX_H))));
                cut_read = 1'b0;
            end
            if ($urandom_range(0, 24) == 0)
                send_item(OP_LOAD, 8'($urandom), CHK_MODEL, 8'h00, 1'b0);
            else
            begin
                send_item(OP_FETCH, 8'($urandom), CHK_MODEL, 8'h00, 1'b0);
                done_n++;
                item_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin : check_results
        pixel_expect_t front;
        if (rst_n && done)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected result: pixel_out %0d, last %0b", pixel_out, last);
                err_count++;
            end
            else
            begin
                front = pending_pixels.pop_front();
                if (pixel_out !== front.pix)
                begin
                    $error("pixel_out mismatch: expected %0d, actual %0d",
                           $signed(front.pix), pixel_out);
                    err_count++;
                end
                if (last !== front.is_last)
                begin
                    $error("last mismatch: expected %0b, actual %0b", front.is_last, last);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        int frame_no;
        // early fetch at the reset size, then 1x1 frames
        add_item(OP_FETCH, 8'h00, CHK_NONE, 8'h00, 1'b0);
        add_size(9'd0, 8'd0);
        add_item(OP_LOAD, ntf_pkg::PIX_MAX_CODE, CHK_NONE, 8'h00, 1'b0);
        add_item(OP_FETCH, 8'h00, CHK_VALUE, ntf_pkg::PIX_MAX_CODE, 1'b1);
        add_item(OP_LOAD, ntf_pkg::PIX_MIN_CODE, CHK_NONE, 8'h00, 1'b0);
        add_item(OP_FETCH, 8'h00, CHK_VALUE, ntf_pkg::PIX_MIN_CODE, 1'b1);
        // 3x3 frame with a load ignored during readout
        add_size(9'd3, 8'd3);
        add_item(OP_LOAD, ntf_pkg::PIX_MIN_CODE, CHK_NONE, 8'h00, 1'b0);
        add_item(OP_LOAD, ntf_pkg::PIX_MAX_CODE, CHK_NONE, 8'h00, 1'b0);
        add_item(OP_LOAD, 8'h00, CHK_NONE, 8'h00, 1'b0);
        add_item(OP_LOAD, 8'hFF, CHK_NONE, 8'h00, 1'b0);
        add_item(OP_LOAD, 8'h01, CHK_NONE, 8'h00, 1'b0);
        add_item(OP_LOAD, 8'h55, CHK_NONE, 8'h00, 1'b0);
        add_item(OP_LOAD, 8'hAA, CHK_NONE, 8'h00, 1'b0);
        add_item(OP_LOAD, 8'h7E, CHK_NONE, 8'h00, 1'b0);
        add_item(OP_LOAD, 8'h81, CHK_NONE, 8'h00, 1'b0);
        add_item(OP_FETCH, 8'h00, CHK_MODEL, 8'h00, 1'b0);
        add_item(OP_FETCH, 8'h00, CHK_VALUE, ntf_pkg::PIX_MAX_CODE, 1'b0);
        add_item(OP_LOAD, 8'h05, CHK_NONE, 8'h00, 1'b0);
        repeat (7) add_item(OP_FETCH, 8'h00, CHK_MODEL, 8'h00, 1'b0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_SIZE)
                write_size(dir_rows[i].w_val, dir_rows[i].h_val);
            else
                send_item(dir_rows[i].op_v, dir_rows[i].pix, dir_rows[i].chk,
                          dir_rows[i].t_pix, dir_rows[i].t_last);
        end

        frame_no = 0;
        while (item_count < RANDOM_ITEMS)
        begin
            gaps_on = (item_count < RANDOM_ITEMS - CALM_ITEMS);
            run_frame(frame_no);
            frame_no++;
        end

        wait_idle();
        if (err_count == 0)
            $display("tb_neighborhood_thicken_filter passed");
        else
            $display("tb_neighborhood_thicken_filter failed");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb_neighborhood_thicken_filter failed");
        $finish;
    end

endmodule

[neighborhood_thicken_filter.f]
rtl/core/ntf_pkg.sv
rtl/core/ntf_div.sv
rtl/core/neighborhood_thicken_filter.sv
sim/tb_neighborhood_thicken_filter.sv
